/* sv/md5_keyspace_search_defines.svh */
// Shared assertion macros for the keyspace search block.
`ifndef MD5_KEYSPACE_SEARCH_DEFINES_SVH
`define MD5_KEYSPACE_SEARCH_DEFINES_SVH

// Check an implication on every rising clock edge outside reset.
`define MD5KS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define MD5KS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/md5ks_pkg.sv */
`default_nettype none
package md5ks_pkg;

  localparam int KEY_CHARS    = 5;
  localparam int DIGIT_BASE   = 58;
  localparam int INDEX_W      = 30;
  localparam int TEXT_W       = 40;
  localparam int ROUNDS       = 64;
  localparam int DIGIT_STAGES = KEY_CHARS - 1;

  localparam logic [INDEX_W-1:0] KEY_SPACE = INDEX_W'(DIGIT_BASE ** KEY_CHARS);
  localparam logic [7:0] FIRST_CODE = 8'd65;
  localparam logic [7:0] LAST_CODE  = 8'd122;

  // floor(x / 58) == (x * DIV_RECIP) >> DIV_SHIFT for every 30-bit x
  localparam int DIV_SHIFT = 36;
  localparam logic [30:0] DIV_RECIP = 31'd1184818565;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef enum logic [7:0] {
    REG_FIRST_HIGH  = 8'd0,
    REG_FIRST_LOW   = 8'd1,
    REG_SECOND_HIGH = 8'd2,
    REG_SECOND_LOW  = 8'd3
  } reg_idx_t;

  // Message words of the padded block that are not zero
  localparam logic [3:0] WORD_KEY_LO  = 4'd0;
  localparam logic [3:0] WORD_KEY_HI  = 4'd1;
  localparam logic [3:0] WORD_BIT_LEN = 4'd14;
  localparam logic [31:0] MSG_BIT_LEN = 32'(KEY_CHARS * 8);

  localparam logic [31:0] ROUND_ADD [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROUND_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic              valid;
    logic              oor;
    logic [TEXT_W-1:0] text;
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
  } lane_t;

  function automatic logic [3:0] word_sel(input logic [5:0] round);
    logic [7:0] r8;
    logic [7:0] g;
    r8 = {2'b00, round};
    case (round[5:4])
      2'd0:    g = r8;
      2'd1:    g = 8'(5 * r8 + 1);
      2'd2:    g = 8'(3 * r8 + 5);
      default: g = 8'(7 * r8);
    endcase
    return g[3:0];
  endfunction

  function automatic logic [31:0] msg_word(input logic [TEXT_W-1:0] text,
                                           input logic [3:0] sel);
    logic [31:0] w;
    case (sel)
      WORD_KEY_LO:  w = {text[15:8], text[23:16], text[31:24], text[39:32]};
      WORD_KEY_HI:  w = {16'h0000, 8'h80, text[7:0]};
      WORD_BIT_LEN: w = MSG_BIT_LEN;
      default:      w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

/* sv/md5ks_round.sv */
`default_nettype none
module md5ks_round
  import md5ks_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [5:0] round_idx,
  input  wire lane_t      prev,
  output lane_t           next
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [4:0]  rot;

  always_comb begin
    case (round_idx[5:4])
      2'd0:    f = (prev.b & prev.c) | (~prev.b & prev.d);
      2'd1:    f = (prev.d & prev.b) | (~prev.d & prev.c);
      2'd2:    f = prev.b ^ prev.c ^ prev.d;
      default: f = prev.c ^ (prev.b | ~prev.d);
    endcase
    sum = prev.a + f + ROUND_ADD[round_idx] + msg_word(prev.text, word_sel(round_idx));
    rot = ROUND_ROT[{round_idx[5:4], round_idx[1:0]}];
    dbl = {sum, sum} << rot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
    if (en) begin
      next.oor  <= prev.oor;
      next.text <= prev.text;
      next.a    <= prev.d;
      next.b    <= prev.b + dbl[63:32];
      next.c    <= prev.b;
      next.d    <= prev.c;
    end
  end

endmodule
`default_nettype wire

/* sv/md5_keyspace_search.sv */
// Pipeline: one key reduce stage, four base-58 digit stages, 64 MD5 round stages,
// a final add stage and a compare stage.
// Throughput: one candidate per cycle; the whole pipeline holds while the result
// register is full and stalled.
// Reset (rst, synchronous): clears all stage valid bits and the four target registers.
`default_nettype none
module md5_keyspace_search
  import md5ks_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [INDEX_W-1:0] candidate_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             digest_high,
  output logic [63:0]             digest_low,
  output logic [TEXT_W-1:0]       candidate_text,
  output logic                    match_first,
  output logic                    match_second,
  output logic                    out_of_range,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [INDEX_W-1:0] rem;
    logic [TEXT_W-1:0]  text;
  } digit_t;

  typedef struct packed {
    logic              valid;
    logic              oor;
    logic [TEXT_W-1:0] text;
    logic [127:0]      digest;
  } final_t;

  logic [63:0] first_high, first_low, second_high, second_low;
  logic        pipe_en;
  digit_t      dg [DIGIT_STAGES+1];
  lane_t       lane [ROUNDS+1];
  final_t      fin;
  logic [7:0]  lead_char, last_char;

  assign pipe_en   = !(out_valid && out_stall);
  assign in_stall  = !pipe_en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_high  <= '0;
      first_low   <= '0;
      second_high <= '0;
      second_low  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_HIGH:  first_high  <= cfg_data;
        REG_FIRST_LOW:   first_low   <= cfg_data;
        REG_SECOND_HIGH: second_high <= cfg_data;
        REG_SECOND_LOW:  second_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Reduce the index into the keyspace; it is always below twice its size.
  always_ff @(posedge clk) begin
    if (rst) begin
      dg[0].valid <= 1'b0;
    end else if (pipe_en) begin
      dg[0].valid <= in_valid;
    end
    if (pipe_en) begin
      dg[0].oor  <= candidate_index >= KEY_SPACE;
      dg[0].rem  <= (candidate_index >= KEY_SPACE) ? candidate_index - KEY_SPACE
                                                   : candidate_index;
      dg[0].text <= '0;
    end
  end

  // Peel one base-58 digit per stage, last character first.
  for (genvar k = 1; k <= DIGIT_STAGES; k++) begin : g_digit
    logic [60:0]        prod;
    logic [24:0]        quot;
    logic [INDEX_W-1:0] q58;
    logic [INDEX_W-1:0] digit;
    logic [TEXT_W-1:0]  text_next;

    always_comb begin
      prod  = {31'd0, dg[k-1].rem} * {30'd0, DIV_RECIP};
      quot  = prod[60:DIV_SHIFT];
      q58   = ({5'd0, quot} << 6) - ({5'd0, quot} << 2) - ({5'd0, quot} << 1);
      digit = dg[k-1].rem - q58;
      text_next = dg[k-1].text;
      text_next[8*(k-1) +: 8] = FIRST_CODE + {2'b00, digit[5:0]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dg[k].valid <= 1'b0;
      end else if (pipe_en) begin
        dg[k].valid <= dg[k-1].valid;
      end
      if (pipe_en) begin
        dg[k].oor  <= dg[k-1].oor;
        dg[k].rem  <= {5'd0, quot};
        dg[k].text <= text_next;
      end
    end
  end

  // The remaining quotient is the leading digit.
  always_comb begin
    lane[0].valid = dg[DIGIT_STAGES].valid;
    lane[0].oor   = dg[DIGIT_STAGES].oor;
    lane[0].text  = dg[DIGIT_STAGES].text;
    lane[0].text[TEXT_W-1 -: 8] = FIRST_CODE + {2'b00, dg[DIGIT_STAGES].rem[5:0]};
    lane[0].a = IV_A;
    lane[0].b = IV_B;
    lane[0].c = IV_C;
    lane[0].d = IV_D;
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    md5ks_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .round_idx (6'(r)),
      .prev      (lane[r]),
      .next      (lane[r+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
    end else if (pipe_en) begin
      fin.valid <= lane[ROUNDS].valid;
    end
    if (pipe_en) begin
      fin.oor    <= lane[ROUNDS].oor;
      fin.text   <= lane[ROUNDS].text;
      fin.digest <= {bswap32(lane[ROUNDS].a + IV_A), bswap32(lane[ROUNDS].b + IV_B),
                     bswap32(lane[ROUNDS].c + IV_C), bswap32(lane[ROUNDS].d + IV_D)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      out_valid <= fin.valid;
    end
    if (pipe_en) begin
      digest_high    <= fin.digest[127:64];
      digest_low     <= fin.digest[63:0];
      candidate_text <= fin.text;
      out_of_range   <= fin.oor;
      match_first    <= !fin.oor && fin.digest == {first_high, first_low};
      match_second   <= !fin.oor && fin.digest == {second_high, second_low};
    end
  end

  assign lead_char = candidate_text[TEXT_W-1 -: 8];
  assign last_char = candidate_text[7:0];

`include "md5_keyspace_search_defines.svh"

  `MD5KS_ASSERT_IMP(a_oor_no_match, out_valid && out_of_range, !match_first && !match_second, "oor match")
  `MD5KS_ASSERT_IMP(a_lead_char, out_valid, lead_char >= FIRST_CODE && lead_char <= LAST_CODE, "lead char")
  `MD5KS_ASSERT_IMP(a_last_char, out_valid, last_char >= FIRST_CODE && last_char <= LAST_CODE, "last char")
  `MD5KS_ASSERT_NEXT(a_hold_front, !pipe_en, $stable(dg[0]), "front stage moved while held")

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  import md5ks_pkg::*;

  localparam int unsigned SPACE = 58 ** 5;
  localparam int unsigned IDX_MAX = (1 << INDEX_W) - 1;
  localparam int DRAIN_CYCLES = 90;

  localparam logic [7:0] REG_UNUSED = 8'd7;

  typedef struct packed {
    logic [63:0]       dig_high;
    logic [63:0]       dig_low;
    logic [TEXT_W-1:0] text;
    logic              hit_first;
    logic              hit_second;
    logic              oor;
  } search_result_t;

  class search_scoreboard;
    logic [63:0] targets [4];
    logic [31:0] sine_add [64];
    search_result_t awaited [$];
    int errors;

    function new();
      real s;
      for (int i = 0; i < 64; i++) begin
        s = $sin(i + 1);
        if (s < 0.0) s = -s;
        sine_add[i] = 32'(longint'($floor(s * 4294967296.0)));
      end
      for (int i = 0; i < 4; i++) targets[i] = '0;
      errors = 0;
    endfunction

    function void set_target(logic [7:0] reg_idx, logic [63:0] value);
      if (reg_idx < 4) targets[reg_idx] = value;
    endfunction

    function search_result_t hash_candidate(logic [INDEX_W-1:0] idx);
      search_result_t r;
      logic [7:0] key [5];
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, sum;
      int unsigned rest, g, sh;
      int rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      rest = 32'(idx);
      for (int i = 4; i >= 0; i--) begin
        key[i] = 8'(65 + rest % 58);
        rest = rest / 58;
      end
      r.text = {key[0], key[1], key[2], key[3], key[4]};
      for (int i = 0; i < 16; i++) w[i] = '0;
      w[0] = {key[3], key[2], key[1], key[0]};
      w[1] = {16'h0, 8'h80, key[4]};
      w[14] = 32'd40;
      a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d); g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d; g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d); g = (7 * i) % 16;
        end
        sh = rot[(i / 16) * 4 + i % 4];
        sum = a + f + sine_add[i] + w[g];
        t = d; d = c; c = b;
        b = b + ((sum << sh) | (sum >> (32 - sh)));
        a = t;
      end
      a += 32'h67452301; b += 32'hefcdab89; c += 32'h98badcfe; d += 32'h10325476;
      // digest bytes leave each word low byte first
      r.dig_high = {a[7:0], a[15:8], a[23:16], a[31:24], b[7:0], b[15:8], b[23:16], b[31:24]};
      r.dig_low = {c[7:0], c[15:8], c[23:16], c[31:24], d[7:0], d[15:8], d[23:16], d[31:24]};
      r.oor = (idx >= SPACE);
      r.hit_first = !r.oor && r.dig_high == targets[0] && r.dig_low == targets[1];
      r.hit_second = !r.oor && r.dig_high == targets[2] && r.dig_low == targets[3];
      return r;
    endfunction

    function void note_candidate(logic [INDEX_W-1:0] idx);
      awaited.push_back(hash_candidate(idx));
    endfunction

    function void check_result(search_result_t got);
      search_result_t exp;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited");
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.dig_high !== exp.dig_high) begin
        $error("digest_high exp %h got %h", exp.dig_high, got.dig_high); errors++;
      end
      if (got.dig_low !== exp.dig_low) begin
        $error("digest_low exp %h got %h", exp.dig_low, got.dig_low); errors++;
      end
      if (got.text !== exp.text) begin
        $error("candidate_text exp %h got %h", exp.text, got.text); errors++;
      end
      if (got.hit_first !== exp.hit_first) begin
        $error("match_first exp %b got %b", exp.hit_first, got.hit_first); errors++;
      end
      if (got.hit_second !== exp.hit_second) begin
        $error("match_second exp %b got %b", exp.hit_second, got.hit_second); errors++;
      end
      if (got.oor !== exp.oor) begin
        $error("out_of_range exp %b got %b", exp.oor, got.oor); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [INDEX_W-1:0] candidate_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] digest_high, digest_low;
  logic [TEXT_W-1:0] candidate_text;
  logic match_first, match_second, out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int send_idle = 10;
  int recv_idle = 70;
  logic [INDEX_W-1:0] hot_a = 30'd12345, hot_b = 30'd600000000, hot_c = 30'd77;
  search_scoreboard board = new();

  always #2 clk = ~clk;

  md5_keyspace_search dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .candidate_index(candidate_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_high(digest_high), .digest_low(digest_low), .candidate_text(candidate_text),
    .match_first(match_first), .match_second(match_second), .out_of_range(out_of_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // result side: check the beat taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({digest_high, digest_low, candidate_text,
                          match_first, match_second, out_of_range});
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_candidate(logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    candidate_index <= idx;
    do @(posedge clk); while (in_stall);
    board.note_candidate(idx);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [7:0] reg_idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_target(reg_idx, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_targets(logic [63:0] fh, logic [63:0] fl, logic [63:0] sh, logic [63:0] sl);
    wait_drained();
    write_reg(REG_FIRST_HIGH, fh);
    write_reg(REG_FIRST_LOW, fl);
    write_reg(REG_SECOND_HIGH, sh);
    write_reg(REG_SECOND_LOW, sl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [INDEX_W-1:0] pick_candidate();
    case ($urandom_range(9))
      0: return hot_a;
      1: return hot_b;
      2: return hot_c;
      3: return INDEX_W'(hot_a + SPACE);
      4: return INDEX_W'($urandom_range(IDX_MAX, SPACE));
      default: return INDEX_W'($urandom_range(SPACE - 1, 0));
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_candidate(pick_candidate());
  endtask

  initial begin
    search_result_t ha, hb, hc;
    ha = board.hash_candidate(hot_a);
    hb = board.hash_candidate(hot_b);
    hc = board.hash_candidate(hot_c);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // targets at reset value: no digest should match
    send_candidate(INDEX_W'(0));
    send_candidate(INDEX_W'(1));
    send_candidate(INDEX_W'(57));
    send_candidate(INDEX_W'(58));
    send_candidate(INDEX_W'(SPACE - 1));
    send_candidate(INDEX_W'(SPACE));
    send_candidate(INDEX_W'(IDX_MAX));
    send_candidate(30'h2AAAAAAA);
    send_candidate(30'h15555555);

    set_targets(ha.dig_high, ha.dig_low, hb.dig_high, hb.dig_low);
    // unmapped register index is dropped
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_candidate(hot_a);
    send_candidate(hot_b);
    send_candidate(INDEX_W'(hot_a + SPACE));
    send_candidate(hot_c);
    send_random(170);

    set_targets('1, '1, hc.dig_high, hc.dig_low);
    send_idle = 70;
    recv_idle = 10;
    send_random(170);

    set_targets(hc.dig_high, hc.dig_low, '0, '0);
    send_idle = 0;
    recv_idle = 0;
    send_candidate(hot_c);
    send_random(150);

    wait_drained();
    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
